/* hw/rtl/mlfq_pkg.sv */
// Package for the three-level feedback queue scheduler.
// Holds the controller state type, command codes, level codes and register codes; no dependencies.
`default_nettype none
package mlfq_pkg;
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_OUT
  } state_t;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [1:0] LVL_ONE   = 2'd0;
  localparam logic [1:0] LVL_TWO   = 2'd1;
  localparam logic [1:0] LVL_THREE = 2'd2;

  localparam logic [1:0] REG_Q1 = 2'd0;
  localparam logic [1:0] REG_Q2 = 2'd1;
  localparam logic [1:0] REG_Q3 = 2'd2;
endpackage
`default_nettype wire

/* hw/rtl/multilevel_feedback_queue_scheduler.sv */
// Top level of the three-level feedback queue scheduler.
// Uses mlfq_pkg and two mlfq_ram instances (queue slots, task records).
//
//  channel | dir | fields (low bit up)
//  in_     | in  | tuser: command; tdata: task_id[3:0], burst_length
//  out_    | out | tuser: idle, finished; tdata: running_task, served_level, tick_time
//  cfg_    | in  | APB, quantum registers at 0x0, 0x4, 0x8
//
// A tick passes through accept, memory read, update and write back, and output.
// A tick on an empty level skips the update; an arrival is accepted and then written, with no output.
// The next input beat is accepted once the result register is free.
// Reset is synchronous; queue and task memories are not cleared, task_active is.
// A stalled out_ beat holds the block in the output state.
`default_nettype none
module multilevel_feedback_queue_scheduler #(
  parameter int MAX_TASKS  = 16,
  parameter int BURST_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [BURST_BITS+4-1:0] in_tdata,  // task_id, burst_length
  input  wire logic                    in_tuser,  // command
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic      [39:0]             out_tdata, // running_task, served_level, tick_time, pad
  output logic      [1:0]              out_tuser, // idle, finished
  input  wire logic                    cfg_psel,
  input  wire logic                    cfg_penable,
  input  wire logic                    cfg_pwrite,
  input  wire logic [3:0]              cfg_paddr,
  input  wire logic [31:0]             cfg_pwdata,
  output logic      [31:0]             cfg_prdata,
  output logic                         cfg_pready
);
  localparam int IW = $clog2(MAX_TASKS);
  localparam int SW = IW + 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int QD = 3 * MAX_TASKS;
  localparam int QAW = $clog2(QD);
  localparam int RW = BURST_BITS + 8;

  mlfq_pkg::state_t state_r, state_nxt;

  logic [7:0] q1_r, q2_r, q3_r;
  logic [IW-1:0] head_r [3];
  logic [CW-1:0] cnt_r [3];
  logic [MAX_TASKS-1:0] act_r;
  logic [1:0] cur_r;
  logic [31:0] tick_r;

  logic cmd_r;
  logic [3:0] tid_r;
  logic [BURST_BITS-1:0] burst_r;

  logic [3:0] o_task_r;
  logic [1:0] o_lvl_r;
  logic o_idle_r, o_fin_r;
  logic [31:0] o_time_r;

  logic q_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [IW-1:0] q_wdata, q_rdata;
  logic t_we;
  logic [IW-1:0] t_waddr, t_raddr;
  logic [RW-1:0] t_wdata, t_rdata;

  logic [1:0] lvl, nxt;
  logic [IW-1:0] id_read;

  assign cfg_pready = 1'b1;
  assign lvl = (cur_r == 2'd3) ? mlfq_pkg::LVL_ONE : cur_r;
  assign nxt = (lvl == mlfq_pkg::LVL_THREE) ? mlfq_pkg::LVL_ONE : lvl + 2'd1;
  assign id_read = q_rdata;

  function automatic logic [QAW-1:0] qaddr(input logic [1:0] l, input logic [IW-1:0] s);
    qaddr = QAW'(l * MAX_TASKS) + QAW'(s);
  endfunction

  function automatic logic [IW-1:0] slot_add(input logic [IW-1:0] h, input logic [CW-1:0] c);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(c);
    if (32'(s) >= MAX_TASKS) s = s - SW'(MAX_TASKS);
    slot_add = s[IW-1:0];
  endfunction

  always_comb begin
    case (cfg_paddr[3:2])
      mlfq_pkg::REG_Q1: cfg_prdata = {24'd0, q1_r};
      mlfq_pkg::REG_Q2: cfg_prdata = {24'd0, q2_r};
      mlfq_pkg::REG_Q3: cfg_prdata = {24'd0, q3_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  mlfq_ram #(.WIDTH(IW), .DEPTH(QD)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );
  mlfq_ram #(.WIDTH(RW), .DEPTH(MAX_TASKS)) u_task (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  // t_raddr follows the queue read of the previous cycle
  assign q_raddr = qaddr(lvl, head_r[lvl]);
  assign t_raddr = id_read;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mlfq_pkg::ST_IDLE: if (in_tvalid) state_nxt = mlfq_pkg::ST_READ;
      mlfq_pkg::ST_READ: state_nxt = (cmd_r == mlfq_pkg::CMD_TICK && cnt_r[lvl] != '0)
                                   ? mlfq_pkg::ST_EXEC
                                   : (cmd_r == mlfq_pkg::CMD_TICK ? mlfq_pkg::ST_OUT
                                                                  : mlfq_pkg::ST_IDLE);
      mlfq_pkg::ST_EXEC: state_nxt = mlfq_pkg::ST_OUT;
      mlfq_pkg::ST_OUT:  if (out_tready) state_nxt = mlfq_pkg::ST_IDLE;
      default:           state_nxt = mlfq_pkg::ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == mlfq_pkg::ST_IDLE);
  assign out_tvalid = (state_r == mlfq_pkg::ST_OUT);
  assign out_tdata  = {2'b00, o_time_r, o_lvl_r, o_task_r};
  assign out_tuser  = {o_fin_r, o_idle_r};

  logic [BURST_BITS-1:0] rem;
  logic [7:0] used, used_inc, quant;
  logic arr_ok, fin, demote;

  assign rem      = t_rdata[BURST_BITS-1:0];
  assign used     = t_rdata[RW-1:BURST_BITS];
  assign used_inc = used + 8'd1;
  always_comb begin
    case (lvl)
      mlfq_pkg::LVL_ONE: quant = q1_r;
      mlfq_pkg::LVL_TWO: quant = q2_r;
      default:           quant = q3_r;
    endcase
    if (quant == 8'd0) quant = 8'd1;
  end
  assign fin    = (rem <= BURST_BITS'(1));
  assign demote = !fin && (used_inc >= quant);
  assign arr_ok = (32'(tid_r) < MAX_TASKS) && !act_r[IW'(tid_r)];

  always_comb begin
    q_we = 1'b0;
    q_waddr = qaddr(mlfq_pkg::LVL_ONE, slot_add(head_r[0], cnt_r[0]));
    q_wdata = IW'(tid_r);
    t_we = 1'b0;
    t_waddr = IW'(tid_r);
    t_wdata = {8'd0, burst_r};
    if (state_r == mlfq_pkg::ST_READ && cmd_r == mlfq_pkg::CMD_ARRIVE && arr_ok) begin
      q_we = (32'(cnt_r[0]) < MAX_TASKS);
      t_we = 1'b1;
    end else if (state_r == mlfq_pkg::ST_EXEC) begin
      t_we = 1'b1;
      t_waddr = id_read;
      t_wdata = fin ? '0 : {demote ? 8'd0 : used_inc, rem - BURST_BITS'(1)};
      q_we = demote && (32'(cnt_r[nxt]) < MAX_TASKS);
      q_waddr = qaddr(nxt, slot_add(head_r[nxt], cnt_r[nxt]));
      q_wdata = id_read;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlfq_pkg::ST_IDLE;
      q1_r <= 8'd4;
      q2_r <= 8'd8;
      q3_r <= 8'd12;
      for (int i = 0; i < 3; i++) begin
        head_r[i] <= '0;
        cnt_r[i] <= '0;
      end
      act_r <= '0;
      cur_r <= mlfq_pkg::LVL_ONE;
      tick_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr[3:2])
          mlfq_pkg::REG_Q1: q1_r <= cfg_pwdata[7:0];
          mlfq_pkg::REG_Q2: q2_r <= cfg_pwdata[7:0];
          mlfq_pkg::REG_Q3: q3_r <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (state_r == mlfq_pkg::ST_READ) begin
        if (cmd_r == mlfq_pkg::CMD_ARRIVE) begin
          if (arr_ok) begin
            act_r[IW'(tid_r)] <= 1'b1;
            if (32'(cnt_r[0]) < MAX_TASKS) cnt_r[0] <= cnt_r[0] + CW'(1);
            cur_r <= mlfq_pkg::LVL_ONE;
          end
        end else begin
          tick_r <= tick_r + 32'd1;
          o_time_r <= tick_r;
          o_lvl_r <= lvl;
          if (cnt_r[lvl] == '0) begin
            cur_r <= nxt;
            o_task_r <= 4'd0;
            o_idle_r <= 1'b1;
            o_fin_r <= 1'b0;
          end
        end
      end
      if (state_r == mlfq_pkg::ST_EXEC) begin
        o_task_r <= 4'(id_read);
        o_idle_r <= 1'b0;
        o_fin_r <= fin;
        if (fin) act_r[id_read] <= 1'b0;
        if (fin || demote) begin
          head_r[lvl] <= (32'(head_r[lvl]) == MAX_TASKS - 1) ? '0 : head_r[lvl] + IW'(1);
          cnt_r[lvl] <= cnt_r[lvl] - CW'(1);
        end
        if (demote && 32'(cnt_r[nxt]) < MAX_TASKS) cnt_r[nxt] <= cnt_r[nxt] + CW'(1);
        if (demote && lvl == mlfq_pkg::LVL_THREE) begin
          cur_r <= mlfq_pkg::LVL_ONE;
        end else if ((fin || demote) && cnt_r[lvl] == CW'(1)) begin
          cur_r <= nxt;
        end else begin
          cur_r <= lvl;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r   <= in_tuser;
      tid_r   <= in_tdata[3:0];
      burst_r <= in_tdata[BURST_BITS+3:4];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/mlfq_ram.sv */
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
